[rtl/swipe_pkg.sv]
// ----------------------------------------------------------------------------
// swipe_pkg
// Shared constants and helpers for the wipe transition pixel selector.
// ----------------------------------------------------------------------------
`default_nettype none

package swipe_pkg;

    // grid geometry
    localparam int GRID_DIM = 16;
    localparam int LAST     = GRID_DIM - 1;

    // step values run up to 2*GRID_DIM-1, pixel step plus one likewise
    localparam int STEP_W  = $clog2(2 * GRID_DIM);
    localparam int POS_W   = 4;
    localparam int CLAMP_W = STEP_W + POS_W;

    // field and register widths
    localparam int COLOR_W = 24;
    localparam int TIME_W  = 32;
    localparam int DIR_W   = 3;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 1;
    localparam int PROD_W  = TIME_W + STEP_W;

    localparam logic [CFG_W-1:0] DURATION_RST = CFG_W'(1000);

    // register indexes
    localparam logic [IDX_W-1:0] CFG_DIRECTION = 1'b0;
    localparam logic [IDX_W-1:0] CFG_DURATION  = 1'b1;

    // wipe directions
    localparam logic [DIR_W-1:0] DIR_ROW    = 3'd0;
    localparam logic [DIR_W-1:0] DIR_COL    = 3'd1;
    localparam logic [DIR_W-1:0] DIR_ROW_R  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_COL_R  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DG_RC  = 3'd4;
    localparam logic [DIR_W-1:0] DIR_DG_RCR = 3'd5;
    localparam logic [DIR_W-1:0] DIR_DG_RRC = 3'd6;
    localparam logic [DIR_W-1:0] DIR_DG_RR  = 3'd7;

    // saturate a position to the last row or column of the grid
    function automatic logic [STEP_W-1:0] clamp_pos(input logic [POS_W-1:0] pos);
        logic [CLAMP_W-1:0] wide;
        begin
            wide = CLAMP_W'(pos);
            if (wide > CLAMP_W'(LAST)) begin
                clamp_pos = STEP_W'(LAST);
            end else begin
                clamp_pos = wide[STEP_W-1:0];
            end
        end
    endfunction

    // step at which a pixel changes over, for the given direction
    function automatic logic [STEP_W-1:0] wipe_pos_step(
        input logic [DIR_W-1:0]  dir,
        input logic [STEP_W-1:0] r,
        input logic [STEP_W-1:0] c
    );
        logic [STEP_W-1:0] rr;
        logic [STEP_W-1:0] rc;
        begin
            rr = STEP_W'(LAST) - r;
            rc = STEP_W'(LAST) - c;
            unique case (dir)
                DIR_ROW:    wipe_pos_step = r;
                DIR_COL:    wipe_pos_step = c;
                DIR_ROW_R:  wipe_pos_step = rr;
                DIR_COL_R:  wipe_pos_step = rc;
                DIR_DG_RC:  wipe_pos_step = r + c;
                DIR_DG_RCR: wipe_pos_step = r + rc;
                DIR_DG_RRC: wipe_pos_step = rr + c;
                DIR_DG_RR:  wipe_pos_step = rr + rc;
                default:    wipe_pos_step = r;
            endcase
        end
    endfunction

endpackage

`default_nettype wire

[rtl/swipe_wipe_pixel_select_unit.sv]
// ----------------------------------------------------------------------------
// swipe_wipe_pixel_select_unit
// Picks old or new colour for each pixel of a wipe transition.
// ----------------------------------------------------------------------------
// One pixel is taken in every clock cycle (busy is always low) and its result
// reaches o_valid through three register stages: position decode, the two
// 32 x 5 bit products, and the final compare and select. The current wipe
// step is never divided out: a pixel keeps its old colour when time <
// duration and time * steps < (pixel step + 1) * duration; the second test
// is the same as pixel step >= floor(time * steps / duration). The receiver
// cannot stall the block, so every result must be taken in its strobe cycle.
// Configuration must only be written while no pixel is in flight.
`default_nettype none

module swipe_wipe_pixel_select_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // pixel input
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [swipe_pkg::POS_W-1:0]         i_row,
    input  wire logic [swipe_pkg::POS_W-1:0]         i_col,
    input  wire logic [swipe_pkg::COLOR_W-1:0]       i_old_color,
    input  wire logic [swipe_pkg::COLOR_W-1:0]       i_new_color,
    input  wire logic [swipe_pkg::TIME_W-1:0]        i_time_ms,
    // configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [swipe_pkg::IDX_W-1:0]         i_cfg_idx,
    input  wire logic [swipe_pkg::CFG_W-1:0]         i_cfg_data,
    // result
    output logic                                     o_valid,
    output logic [swipe_pkg::COLOR_W-1:0]            o_pixel_color,
    output logic                                     o_progressing
);

    // configuration registers
    logic [swipe_pkg::DIR_W-1:0]   r_direction;
    logic [swipe_pkg::TIME_W-1:0]  r_duration;

    // stage 1: decoded position
    logic                           r_s1_valid;
    logic [swipe_pkg::STEP_W-1:0]  r_s1_pstep1;
    logic [swipe_pkg::STEP_W-1:0]  r_s1_steps;
    logic [swipe_pkg::TIME_W-1:0]  r_s1_time;
    logic                           r_s1_run;
    logic [swipe_pkg::COLOR_W-1:0] r_s1_old;
    logic [swipe_pkg::COLOR_W-1:0] r_s1_new;

    // stage 2: products
    logic                           r_s2_valid;
    logic [swipe_pkg::PROD_W-1:0]  r_s2_lhs;
    logic [swipe_pkg::PROD_W-1:0]  r_s2_rhs;
    logic                           r_s2_run;
    logic [swipe_pkg::COLOR_W-1:0] r_s2_old;
    logic [swipe_pkg::COLOR_W-1:0] r_s2_new;

    // stage 3: output
    logic                           r_s3_valid;
    logic [swipe_pkg::COLOR_W-1:0] r_s3_color;
    logic                           r_s3_run;

    logic                           n_s1_valid;
    logic [swipe_pkg::STEP_W-1:0]  n_s1_pstep1;
    logic [swipe_pkg::STEP_W-1:0]  n_s1_steps;
    logic [swipe_pkg::COLOR_W-1:0] n_s3_color;

    // the pipeline never stalls
    assign busy       = 1'b0;
    assign n_s1_valid = start & ~busy;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= swipe_pkg::DIR_ROW;
            r_duration  <= swipe_pkg::DURATION_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                swipe_pkg::CFG_DIRECTION: r_direction <= i_cfg_data[swipe_pkg::DIR_W-1:0];
                swipe_pkg::CFG_DURATION:  r_duration  <= i_cfg_data[swipe_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // pixel step and step count for the current direction
    always_comb begin
        n_s1_pstep1 = swipe_pkg::wipe_pos_step(r_direction,
                                               swipe_pkg::clamp_pos(i_row),
                                               swipe_pkg::clamp_pos(i_col))
                      + swipe_pkg::STEP_W'(1);
        if (r_direction[swipe_pkg::DIR_W-1]) begin
            n_s1_steps = swipe_pkg::STEP_W'(2 * swipe_pkg::GRID_DIM - 1);
        end else begin
            n_s1_steps = swipe_pkg::STEP_W'(swipe_pkg::GRID_DIM);
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (n_s1_valid) begin
            r_s1_pstep1 <= n_s1_pstep1;
            r_s1_steps  <= n_s1_steps;
            r_s1_time   <= i_time_ms;
            r_s1_run    <= (i_time_ms < r_duration);
            r_s1_old    <= i_old_color;
            r_s1_new    <= i_new_color;
        end
    end

    // stage 2 payload: both sides of the step compare
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_lhs <= swipe_pkg::PROD_W'(r_s1_time) * swipe_pkg::PROD_W'(r_s1_steps);
            r_s2_rhs <= swipe_pkg::PROD_W'(r_s1_pstep1) * swipe_pkg::PROD_W'(r_duration);
            r_s2_run <= r_s1_run;
            r_s2_old <= r_s1_old;
            r_s2_new <= r_s1_new;
        end
    end

    // old colour only while running and the pixel has not been reached
    always_comb begin
        if (r_s2_run && (r_s2_lhs < r_s2_rhs)) begin
            n_s3_color = r_s2_old;
        end else begin
            n_s3_color = r_s2_new;
        end
    end

    // stage 3 payload
    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_s3_color <= n_s3_color;
            r_s3_run   <= r_s2_run;
        end
    end

    // result beat
    assign o_valid       = r_s3_valid;
    assign o_pixel_color = r_s3_color;
    assign o_progressing = r_s3_run;

endmodule

`default_nettype wire
